// ===== design/bvma_pkg.sv =====
// shared widths, constants and helpers for the battery voltage moving average core
`timescale 1ns / 1ps
`default_nettype none
package bvma_pkg;

   localparam int CODE_W    = 16;
   localparam int CURRENT_W = 15;
   localparam int REG_W     = 16;
   localparam int SAMPLE_W  = 18;

   localparam int SAMPLE_MAX  = 131071;
   localparam int SAMPLE_MIN  = -131072;
   localparam int SAMPLE_BIAS = 131072;

   localparam int HISTORY_DEPTH_DEFAULT = 60;

   localparam logic [REG_W-1:0] VOLTS_PER_COUNT_RESET   = 16'd31703;
   localparam logic [REG_W-1:0] WIRING_RESISTANCE_RESET = 16'd6554;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // signed width of a sum of depth samples
   function automatic int total_width(input int depth);
      return $clog2(depth * SAMPLE_BIAS) + 1;
   endfunction

endpackage
`default_nettype wire

// ===== design/bvma_front.sv =====
// scaling, drop correction, rounding and saturation of one request
`timescale 1ns / 1ps
`default_nettype none
module bvma_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                in_valid,
   input  wire logic signed [bvma_pkg::CODE_W-1:0]  adc_code,
   input  wire logic [bvma_pkg::CURRENT_W-1:0]      charger_current,
   input  wire logic [bvma_pkg::REG_W-1:0]          volts_per_count,
   input  wire logic [bvma_pkg::REG_W-1:0]          wiring_resistance,
   output logic                                     out_valid,
   output bvma_pkg::sample_type                     sample
);
   import bvma_pkg::*;

   logic               mul_valid_ff;
   logic signed [32:0] measured_ff;
   logic [30:0]        drop_ff;
   logic               sample_valid_ff;
   sample_type         sample_ff;

   logic signed [32:0] measured_in;
   logic [30:0]        drop_in;
   logic [33:0]        diff;
   logic [33:0]        rounded;
   logic signed [19:0] quotient;
   sample_type         sample_in;

   always_comb begin
      measured_in = $signed(adc_code) * $signed({1'b0, volts_per_count});
      drop_in     = 31'(charger_current) * 31'(wiring_resistance);
   end

   // floor((measured - drop + 2^13) / 2^14), then clamp to 18 bits
   always_comb begin
      diff     = {measured_ff[32], measured_ff} - {3'b000, drop_ff};
      rounded  = diff + 34'd8192;
      quotient = $signed(rounded[33:14]);
      if (quotient > 20'(SAMPLE_MAX)) begin
         sample_in = sample_type'(SAMPLE_MAX);
      end else if (quotient < $signed(20'(SAMPLE_MIN))) begin
         sample_in = sample_type'(SAMPLE_MIN);
      end else begin
         sample_in = quotient[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff    <= 1'b0;
         sample_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff    <= in_valid;
         sample_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         measured_ff <= measured_in;
         drop_ff     <= drop_in;
         sample_ff   <= sample_in;
      end
   end

   assign out_valid = sample_valid_ff;
   assign sample    = sample_ff;

endmodule
`default_nettype wire

// ===== design/bvma_cell.sv =====
// one history cell of the sample shift chain
`timescale 1ns / 1ps
`default_nettype none
module bvma_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire bvma_pkg::sample_type shift_data,
   output bvma_pkg::sample_type      held_sample
);
   import bvma_pkg::*;

   sample_type sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= shift_data;
      end
   end

   assign held_sample = sample_ff;

endmodule
`default_nettype wire

// ===== design/bvma_mean.sv =====
// rounded division of the running total by the history depth
`timescale 1ns / 1ps
`default_nettype none
module bvma_mean #(
   parameter int HISTORY_DEPTH = bvma_pkg::HISTORY_DEPTH_DEFAULT,
   localparam int TotalW = bvma_pkg::total_width(HISTORY_DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire logic signed [TotalW-1:0] total,
   output logic                          out_valid,
   output bvma_pkg::sample_type          average
);
   import bvma_pkg::*;

   // num = 2 * (total + D * 2^17) + D, quotient = floor(num / (2 * D))
   localparam longint unsigned NumBias = 2 * longint'(HISTORY_DEPTH) * SAMPLE_BIAS
                                       + longint'(HISTORY_DEPTH);
   localparam longint unsigned NumMax  = 2 * longint'(HISTORY_DEPTH) * (2 * SAMPLE_BIAS - 1)
                                       + longint'(HISTORY_DEPTH);
   localparam int              NumW    = $clog2(NumMax + 1);
   localparam longint unsigned Div     = 2 * longint'(HISTORY_DEPTH);
   localparam int              DivL    = $clog2(Div);
   localparam int              Shift   = NumW + DivL;
   localparam longint unsigned Mult    = ((longint'(1) << Shift) + Div - 1) / Div;
   localparam int              MultW   = NumW + 1;
   localparam int              ProdW   = NumW + MultW;

   logic              num_valid_ff;
   logic [NumW-1:0]   num_ff;
   logic              prod_valid_ff;
   logic [ProdW-1:0]  prod_ff;

   logic [NumW-1:0]   total_ext;
   logic [NumW-1:0]   num_in;
   logic [ProdW-1:0]  prod_in;

   always_comb begin
      total_ext = {{(NumW - TotalW){total[TotalW-1]}}, total};
      num_in    = (total_ext << 1) + NumW'(NumBias);
      prod_in   = ProdW'(num_ff) * ProdW'(MultW'(Mult));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         num_valid_ff  <= in_valid;
         prod_valid_ff <= num_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= num_in;
         prod_ff <= prod_in;
      end
   end

   // quotient lies in [0, 2^18), removing the bias flips the top bit
   assign out_valid = prod_valid_ff;
   assign average   = {~prod_ff[Shift+SAMPLE_W-1], prod_ff[Shift+SAMPLE_W-2:Shift]};

endmodule
`default_nettype wire

// ===== design/battery_voltage_moving_average_core.sv =====
// top level of the battery voltage moving average core
//
//   channel  direction  handshake                  payload
//   req      in         req_tvalid / req_tready    adc_code, charger_current
//   rsp      out        rsp_tvalid / rsp_tready    average_voltage
//   csr      in         apb psel / penable         volts_per_count, wiring_resistance
//
// one request per cycle sustained while the output buffer has room; rsp_tvalid for a
// request rises once it has passed the two front stages, the cell chain and running
// total, the two divide stages and the output register. reset clears every history
// cell, the total and the pipe at once. a two-entry output buffer holds responses
// while rsp_tready is low; req_tready drops only once both entries are full, and the
// whole pipe then holds.
`timescale 1ns / 1ps
`default_nettype none
module battery_voltage_moving_average_core #(
   parameter int HISTORY_DEPTH = bvma_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // adc_code [15:0], charger_current [30:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // average_voltage [17:0]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bvma_pkg::*;

   localparam int TotalW = total_width(HISTORY_DEPTH);

   typedef enum logic {
      CSR_VOLTS_PER_COUNT   = 1'b0,
      CSR_WIRING_RESISTANCE = 1'b1
   } csr_index_type;

   logic [REG_W-1:0]          volts_per_count_ff;
   logic [REG_W-1:0]          wiring_resistance_ff;
   logic                      chain_valid_ff;
   logic signed [TotalW-1:0]  total_ff;
   logic                      out_valid_ff;
   sample_type                out_ff;
   logic                      skid_valid_ff;
   sample_type                skid_ff;

   logic                      advance;
   logic                      front_valid;
   sample_type                front_sample;
   logic                      shift_en;
   sample_type                cell_q [HISTORY_DEPTH];
   logic signed [TotalW-1:0]  total_in;
   logic                      mean_valid;
   sample_type                mean_average;
   logic                      push;
   logic                      pop;
   logic                      csr_write;
   csr_index_type             csr_index;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         volts_per_count_ff   <= VOLTS_PER_COUNT_RESET;
         wiring_resistance_ff <= WIRING_RESISTANCE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VOLTS_PER_COUNT:   volts_per_count_ff   <= csr_pwdata[REG_W-1:0];
            CSR_WIRING_RESISTANCE: wiring_resistance_ff <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_VOLTS_PER_COUNT:   csr_prdata = {16'b0, volts_per_count_ff};
         CSR_WIRING_RESISTANCE: csr_prdata = {16'b0, wiring_resistance_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // pipe advance
   assign advance    = ~skid_valid_ff;
   assign req_tready = advance;

   bvma_front u_front (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (req_tvalid),
      .adc_code          ($signed(req_tdata[15:0])),
      .charger_current   (req_tdata[30:16]),
      .volts_per_count   (volts_per_count_ff),
      .wiring_resistance (wiring_resistance_ff),
      .out_valid         (front_valid),
      .sample            (front_sample)
   );

   // history chain, oldest sample at the far end
   assign shift_en = advance & front_valid;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         bvma_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift_en    (shift_en),
            .shift_data  (front_sample),
            .held_sample (cell_q[i])
         );
      end else begin : g_body
         bvma_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift_en    (shift_en),
            .shift_data  (cell_q[i-1]),
            .held_sample (cell_q[i])
         );
      end
   end

   assign total_in = total_ff + TotalW'(front_sample) - TotalW'(cell_q[HISTORY_DEPTH-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= '0;
         chain_valid_ff <= 1'b0;
      end else if (advance) begin
         chain_valid_ff <= front_valid;
         if (front_valid) begin
            total_ff <= total_in;
         end
      end
   end

   bvma_mean #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (chain_valid_ff),
      .total     (total_ff),
      .out_valid (mean_valid),
      .average   (mean_average)
   );

   // two-entry output buffer
   assign push = advance & mean_valid;
   assign pop  = out_valid_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (push && (pop || !out_valid_ff)) begin
         out_ff <= mean_average;
      end
      if (push && out_valid_ff && !pop) begin
         skid_ff <= mean_average;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ff};

endmodule
`default_nettype wire

// ===== tb/battery_voltage_moving_average_core_test.sv =====
// self-checking testbench for the battery voltage moving average core
`timescale 1ns / 1ps
module battery_voltage_moving_average_core_test;
   import bvma_pkg::*;

   localparam int DEPTH            = HISTORY_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int PHASE_COUNT      = 10;
   localparam int RANDOM_PER_PHASE = 85;
   localparam int SETTLE_CYCLES    = 12;

   localparam logic [2:0] VOLTS_PER_COUNT_ADDR   = 3'd0;
   localparam logic [2:0] WIRING_RESISTANCE_ADDR = 3'd4;

   typedef struct packed {
      logic [CURRENT_W-1:0]     current;
      logic signed [CODE_W-1:0] code;
   } voltage_request_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   battery_voltage_moving_average_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   voltage_request_type pending_requests[$];
   sample_type          expected_averages[$];
   int                  sender_idle_pct = 11;
   int                  receiver_idle_pct = 54;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   sample_type       history[DEPTH] = '{default: '0};
   int unsigned      next_slot = 0;
   longint           history_total = 0;
   logic [REG_W-1:0] model_volts_per_count = VOLTS_PER_COUNT_RESET;
   logic [REG_W-1:0] model_wiring_resistance = WIRING_RESISTANCE_RESET;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // scale, drop-correct, round and saturate one sample, then update the ring mean
   function automatic sample_type filtered_average(input voltage_request_type item);
      longint corrected;
      longint biased;
      corrected = (longint'($signed(item.code)) * longint'(model_volts_per_count)
                 - longint'(item.current) * longint'(model_wiring_resistance)
                 + 8192) >>> 14;
      if (corrected < SAMPLE_MIN) corrected = SAMPLE_MIN;
      if (corrected > SAMPLE_MAX) corrected = SAMPLE_MAX;
      history_total += corrected - longint'(history[next_slot]);
      history[next_slot] = sample_type'(corrected);
      next_slot = (next_slot + 1) % DEPTH;
      biased = history_total + longint'(DEPTH) * SAMPLE_BIAS;
      return sample_type'((2 * biased + DEPTH) / (2 * DEPTH) - SAMPLE_BIAS);
   endfunction

   function automatic voltage_request_type random_request();
      voltage_request_type item;
      item.code = CODE_W'($urandom);
      item.current = CURRENT_W'($urandom_range(25600));
      case ($urandom_range(9))
         0: item.current = CURRENT_W'($urandom);
         1: item.code = $urandom_range(1) ? 16'h7fff : 16'h8000;
         2, 3, 4: item.code = CODE_W'($urandom_range(26000, 18000));
         default: ;
      endcase
      return item;
   endfunction

   task automatic push_request(input logic [CODE_W-1:0] code,
                               input logic [CURRENT_W-1:0] current);
      voltage_request_type item;
      item.code = code;
      item.current = current;
      pending_requests.push_back(item);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_averages.size() != 0)
         @(posedge clock);
   endtask

   // apb write followed by a readback of the same register
   task automatic write_register(input logic [2:0] addr, input logic [REG_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == VOLTS_PER_COUNT_ADDR) model_volts_per_count = value;
      else model_wiring_resistance = value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[REG_W-1:0] !== value)
         report_mismatch($sformatf("register %0d reads %0d, wrote %0d",
                                   addr, csr_prdata[REG_W-1:0], value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_tdata <= {1'b0, pending_requests.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= $urandom_range(99) >= receiver_idle_pct;
      end
   end

   always @(posedge clock) begin : response_check
      sample_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_averages.push_back(filtered_average(req_tdata[30:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_averages.size() == 0) begin
               report_mismatch($sformatf("unexpected average %0d",
                                         $signed(rsp_tdata[SAMPLE_W-1:0])));
            end else begin
               want = expected_averages.pop_front();
               if (rsp_tdata[SAMPLE_W-1:0] !== want)
                  report_mismatch($sformatf("average_voltage %0d, expected %0d",
                                            $signed(rsp_tdata[SAMPLE_W-1:0]), want));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("battery_voltage_moving_average_core test failed");
         $finish;
      end
   end

   initial begin : sequencer
      logic [CODE_W-1:0]    corner_codes[4];
      logic [CURRENT_W-1:0] corner_currents[3];
      logic [REG_W-1:0]     volts_setting;
      logic [REG_W-1:0]     resistance_setting;
      corner_codes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      corner_currents = '{15'd0, 15'd32767, 15'd25600};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase >= 7) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end else if (phase >= 4) begin
            sender_idle_pct = 54;
            receiver_idle_pct = 11;
         end
         if (phase > 0) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clock);
            case (phase)
               1: begin volts_setting = 16'hffff; resistance_setting = 16'hffff; end
               2: begin volts_setting = 16'h0000; resistance_setting = 16'h0000; end
               3: begin volts_setting = 16'd8192; resistance_setting = 16'h0000; end
               4: begin volts_setting = 16'h0000; resistance_setting = 16'hffff; end
               5: begin volts_setting = 16'hffff; resistance_setting = 16'h0000; end
               default: begin
                  volts_setting = REG_W'($urandom);
                  resistance_setting = REG_W'($urandom);
               end
            endcase
            write_register(VOLTS_PER_COUNT_ADDR, volts_setting);
            write_register(WIRING_RESISTANCE_ADDR, resistance_setting);
         end
         if (phase == 0) begin
            foreach (corner_codes[i])
               foreach (corner_currents[j])
                  push_request(corner_codes[i], corner_currents[j]);
         end else if (phase == 1) begin
            // negative full scale with maximum drop drives the sample into negative saturation
            foreach (corner_codes[i]) begin
               push_request(corner_codes[i], 15'd0);
               push_request(corner_codes[i], 15'd32767);
            end
         end else if (phase == 3) begin
            // half-lsb ties round toward plus infinity
            push_request(16'd1, 15'd0);
            push_request(16'hffff, 15'd0);
            push_request(16'd3, 15'd0);
            push_request(16'hfffd, 15'd0);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            pending_requests.push_back(random_request());
      end
      wait_drained();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatch_count == 0 && expected_averages.size() == 0) begin
         $display("battery_voltage_moving_average_core test passed");
      end else begin
         $display("battery_voltage_moving_average_core test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/bvma_pkg.sv
design/bvma_front.sv
design/bvma_cell.sv
design/bvma_mean.sv
design/battery_voltage_moving_average_core.sv
tb/battery_voltage_moving_average_core_test.sv
